// ===== rtl/core/intensity_to_rgba_colormap_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the intensity-to-RGBA colormap
// Assertions are compiled in simulation and drop out of synthesis.
// ----------------------------------------------------------------------------
`ifndef INTENSITY_TO_RGBA_COLORMAP_TOP_DEFINES_SVH
`define INTENSITY_TO_RGBA_COLORMAP_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ICM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("icm assertion failed");
// Next-cycle implication.
`define ICM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("icm assertion failed");
`else
`define ICM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ICM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/icm_pkg.sv =====
// ----------------------------------------------------------------------------
// icm_pkg
// Shared types and constants of the intensity-to-RGBA colormap.
// ----------------------------------------------------------------------------
package icm_pkg;

	localparam int LEVEL_W   = 8;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_W     = 16;
	localparam int COLOR_W   = 32;

	localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_LUMA     = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HUE           = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SATURATION    = 8'd3;

	// 1.0 at 16, 32 and 48 bits of scale (65535^k)
	localparam logic [15:0] ONE16  = 16'hFFFF;
	localparam logic [31:0] ONE32  = 32'hFFFE_0001;
	localparam logic [47:0] ONE48  = 48'hFFFD_0002_FFFF;
	localparam logic [47:0] HALF48 = ONE48 >> 1;

	typedef struct packed {
		logic [CFG_W-1:0] low_threshold;
		logic [CFG_W-1:0] base_luma;
		logic [CFG_W-1:0] hue;
		logic [CFG_W-1:0] saturation;
	} cfg_t;

	typedef struct packed {
		logic               en;
		logic [LEVEL_W-1:0] addr;
		logic [COLOR_W-1:0] data;
	} lut_wr_t;

	typedef enum logic [3:0] {
		BS_IDLE,
		BS_SETUP_D,
		BS_SETUP_T,
		BS_LEVEL,
		BS_NUM,
		BS_LDIV,
		BS_X,
		BS_MUL,
		BS_CINIT,
		BS_CDIV,
		BS_WRITE
	} bld_state_t;

	typedef enum logic [1:0] {
		CH_V,
		CH_P,
		CH_Q,
		CH_T
	} chan_t;

endpackage

// ===== rtl/core/icm_cfg.sv =====
// ----------------------------------------------------------------------------
// icm_cfg
// Configuration register file; flags every write beat to restart the build.
// ----------------------------------------------------------------------------
module icm_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [icm_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [icm_pkg::CFG_W-1:0]      wr_data,
	output icm_pkg::cfg_t                  cfg,
	output logic                           restart
);

	icm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				icm_pkg::REG_LOW_THRESHOLD: cfg_q.low_threshold <= wr_data;
				icm_pkg::REG_BASE_LUMA:     cfg_q.base_luma     <= wr_data;
				icm_pkg::REG_HUE:           cfg_q.hue           <= wr_data;
				icm_pkg::REG_SATURATION:    cfg_q.saturation    <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg     = cfg_q;
	assign restart = wr_en;

endmodule

// ===== rtl/core/icm_builder.sv =====
// ----------------------------------------------------------------------------
// icm_builder
// Sequencer that computes the color of every level and writes it to the table.
// ----------------------------------------------------------------------------
`include "intensity_to_rgba_colormap_top_defines.svh"

module icm_builder #(
	parameter int MAX_LEVEL = 255
) (
	input  logic             clk,
	input  logic             arst_n,
	input  icm_pkg::cfg_t    cfg,
	input  logic             restart,
	output logic             busy,
	output icm_pkg::lut_wr_t wr
);

	localparam logic [15:0] M16 = 16'(MAX_LEVEL);

	icm_pkg::bld_state_t state_q, state_d;
	icm_pkg::chan_t      k_q;

	logic [icm_pkg::LEVEL_W-1:0] idx_q;
	logic [3:0]  cnt_q;
	logic [31:0] d_q, thr_q, n_q, rem_q, x_q;
	logic        cut_q;
	logic [15:0] lo_q;
	logic [55:0] mp_q;
	logic [55:0] cnum_q;
	logic [7:0]  ch_q [4];

	// hue sector and fraction
	logic [18:0] h6;
	logic [2:0]  sec_raw, sector;
	logic [16:0] fr_raw;
	logic [15:0] fr;
	always_comb begin
		h6     = {1'b0, cfg.hue, 2'b00} + {2'b00, cfg.hue, 1'b0};
		fr_raw = {1'b0, h6[15:0]} + 17'(h6[18:16]);
		if (fr_raw >= 17'(icm_pkg::ONE16)) begin
			sec_raw = h6[18:16] + 3'd1;
			fr      = 16'(fr_raw - 17'(icm_pkg::ONE16));
		end else begin
			sec_raw = h6[18:16];
			fr      = fr_raw[15:0];
		end
		sector = (sec_raw >= 3'd6) ? 3'd0 : sec_raw;
	end

	logic [15:0] lev_c;
	assign lev_c = ({8'd0, idx_q} > M16) ? M16 : {8'd0, idx_q};

	// level-side datapath
	logic [31:0] dn;
	logic [47:0] lnum;
	logic [32:0] lt_sh;
	logic        lge;
	always_comb begin
		dn    = d_q - n_q;
		lnum  = {dn, 16'h0000} - {16'h0000, dn} + {17'd0, d_q[31:1]};
		lt_sh = {rem_q, lo_q[15]};
		lge   = lt_sh >= {1'b0, d_q};
	end

	// channel-side datapath
	logic [15:0] mb;
	logic [31:0] sprod, xval;
	logic [15:0] nsat;
	logic [23:0] lum255;
	logic [55:0] cnum;
	logic [7:0]  cest;
	logic [8:0]  cest1;
	logic [9:0]  cest3;
	logic [57:0] cbound;
	logic        cge;
	always_comb begin
		nsat   = icm_pkg::ONE16 - cfg.saturation;
		mb     = (k_q == icm_pkg::CH_Q) ? fr : (icm_pkg::ONE16 - fr);
		sprod  = 32'(mb) * 32'(cfg.saturation);
		unique case (k_q)
			icm_pkg::CH_V: xval = icm_pkg::ONE32;
			icm_pkg::CH_P: xval = {nsat, 16'h0000} - {16'h0000, nsat};
			icm_pkg::CH_Q: xval = icm_pkg::ONE32 - sprod;
			icm_pkg::CH_T: xval = icm_pkg::ONE32 - sprod;
			default:       xval = icm_pkg::ONE32;
		endcase
		lum255 = {lo_q, 8'h00} - {8'h00, lo_q};
		cnum   = mp_q + {8'h00, icm_pkg::HALF48};
		// Divide by 65535^3: the top byte is the quotient or one below it,
		// so compare against (top byte + 1) * 65535^3 and bump on a hit.
		cest   = cnum_q[55:48];
		cest1  = {1'b0, cest} + 9'd1;
		cest3  = {cest1, 1'b0} + {1'b0, cest1};
		cbound = {1'b0, cest1, 48'h0} - {16'h0, cest3, 32'h0}
			+ {32'h0, cest3, 16'h0} - {49'h0, cest1};
		cge    = {2'b00, cnum_q} >= cbound;
	end

	// next state
	always_comb begin
		state_d = state_q;
		priority if (restart) begin
			state_d = icm_pkg::BS_SETUP_D;
		end else begin
			unique case (state_q)
				icm_pkg::BS_IDLE:    state_d = icm_pkg::BS_IDLE;
				icm_pkg::BS_SETUP_D: state_d = icm_pkg::BS_SETUP_T;
				icm_pkg::BS_SETUP_T: state_d = icm_pkg::BS_LEVEL;
				icm_pkg::BS_LEVEL:   state_d = icm_pkg::BS_NUM;
				icm_pkg::BS_NUM:     state_d = cut_q ? icm_pkg::BS_WRITE : icm_pkg::BS_LDIV;
				icm_pkg::BS_LDIV:    if (cnt_q == 4'd0) state_d = icm_pkg::BS_X;
				icm_pkg::BS_X:       state_d = icm_pkg::BS_MUL;
				icm_pkg::BS_MUL:     state_d = icm_pkg::BS_CINIT;
				icm_pkg::BS_CINIT:   state_d = icm_pkg::BS_CDIV;
				icm_pkg::BS_CDIV: begin
					state_d = (k_q == icm_pkg::CH_T) ? icm_pkg::BS_WRITE : icm_pkg::BS_X;
				end
				icm_pkg::BS_WRITE: begin
					state_d = (idx_q == '1) ? icm_pkg::BS_IDLE : icm_pkg::BS_LEVEL;
				end
				default: state_d = icm_pkg::BS_IDLE;
			endcase
		end
	end

	// outputs
	logic [7:0] r, g, b;
	always_comb begin
		unique case (sector)
			3'd0:    begin r = ch_q[icm_pkg::CH_V]; g = ch_q[icm_pkg::CH_T]; b = ch_q[icm_pkg::CH_P]; end
			3'd1:    begin r = ch_q[icm_pkg::CH_Q]; g = ch_q[icm_pkg::CH_V]; b = ch_q[icm_pkg::CH_P]; end
			3'd2:    begin r = ch_q[icm_pkg::CH_P]; g = ch_q[icm_pkg::CH_V]; b = ch_q[icm_pkg::CH_T]; end
			3'd3:    begin r = ch_q[icm_pkg::CH_P]; g = ch_q[icm_pkg::CH_Q]; b = ch_q[icm_pkg::CH_V]; end
			3'd4:    begin r = ch_q[icm_pkg::CH_T]; g = ch_q[icm_pkg::CH_P]; b = ch_q[icm_pkg::CH_V]; end
			default: begin r = ch_q[icm_pkg::CH_V]; g = ch_q[icm_pkg::CH_P]; b = ch_q[icm_pkg::CH_Q]; end
		endcase
		busy    = state_q != icm_pkg::BS_IDLE;
		wr.en   = state_q == icm_pkg::BS_WRITE;
		wr.addr = idx_q;
		wr.data = cut_q ? '0 : {8'hFF, b, g, r};
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= icm_pkg::BS_SETUP_D;
			idx_q   <= '0;
			cnt_q   <= '0;
			k_q     <= icm_pkg::CH_V;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				icm_pkg::BS_SETUP_D: idx_q <= '0;
				icm_pkg::BS_NUM: begin
					cnt_q <= 4'd15;
					k_q   <= icm_pkg::CH_V;
				end
				icm_pkg::BS_LDIV:  cnt_q <= cnt_q - 4'd1;
				icm_pkg::BS_CDIV: begin
					if (k_q != icm_pkg::CH_T) begin
						k_q <= icm_pkg::chan_t'(k_q + 2'd1);
					end
				end
				icm_pkg::BS_WRITE: idx_q <= idx_q + 1'b1;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			icm_pkg::BS_SETUP_D: begin
				d_q <= 32'(M16) * 32'(icm_pkg::ONE16 - cfg.low_threshold);
			end
			icm_pkg::BS_SETUP_T: thr_q <= 32'(M16) * 32'(cfg.low_threshold);
			icm_pkg::BS_LEVEL: begin
				n_q   <= 32'(icm_pkg::ONE16 - cfg.base_luma) * 32'(M16 - lev_c);
				cut_q <= ({lev_c, 16'h0000} - {16'h0000, lev_c}) <= thr_q;
			end
			icm_pkg::BS_NUM: begin
				rem_q <= lnum[47:16];
				lo_q  <= lnum[15:0];
			end
			icm_pkg::BS_LDIV: begin
				rem_q <= lge ? 32'(lt_sh - {1'b0, d_q}) : lt_sh[31:0];
				lo_q  <= {lo_q[14:0], lge};
			end
			icm_pkg::BS_X:     x_q    <= xval;
			icm_pkg::BS_MUL:   mp_q   <= 56'(lum255) * 56'(x_q);
			icm_pkg::BS_CINIT: cnum_q <= cnum;
			icm_pkg::BS_CDIV:  ch_q[k_q] <= cest + {7'd0, cge};
			default: ;
		endcase
	end

	`ICM_ASSERT_NEXT(a_restart_setup, clk, arst_n, restart, state_q == icm_pkg::BS_SETUP_D)

endmodule

// ===== rtl/core/icm_lut.sv =====
// ----------------------------------------------------------------------------
// icm_lut
// Color table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module icm_lut (
	input  logic                          clk,
	input  icm_pkg::lut_wr_t              wr,
	input  logic                          rd_en,
	input  logic [icm_pkg::LEVEL_W-1:0]   rd_addr,
	output logic [icm_pkg::COLOR_W-1:0]   rd_data
);

	logic [icm_pkg::COLOR_W-1:0] mem [2**icm_pkg::LEVEL_W];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/icm_ofifo.sv =====
// ----------------------------------------------------------------------------
// icm_ofifo
// Three-entry output queue that decouples table reads from downstream stall.
// ----------------------------------------------------------------------------
`include "intensity_to_rgba_colormap_top_defines.svh"

module icm_ofifo (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic [icm_pkg::COLOR_W-1:0] push_data,
	input  logic                        pop,
	output logic                        not_empty,
	output logic [icm_pkg::COLOR_W-1:0] head_data,
	output logic [1:0]                  count
);

	logic [icm_pkg::COLOR_W-1:0] buf_q [3];
	logic [1:0] wp_q, rp_q, cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == 2'd2) ? 2'd0 : wp_q + 2'd1;
			if (pop)  rp_q <= (rp_q == 2'd2) ? 2'd0 : rp_q + 2'd1;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wp_q] <= push_data;
	end

	assign not_empty = cnt_q != 2'd0;
	assign head_data = buf_q[rp_q];
	assign count     = cnt_q;

	`ICM_ASSERT_IMPL(a_no_overflow, clk, arst_n, push && !pop, cnt_q != 2'd3)
	`ICM_ASSERT_NEXT(a_count_up, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 2'd1)

endmodule

// ===== rtl/core/intensity_to_rgba_colormap_top.sv =====
// ----------------------------------------------------------------------------
// intensity_to_rgba_colormap_top
// Maps an intensity level to a packed RGBA color through a per-level table.
// ----------------------------------------------------------------------------
//  channel  | signals                               | beat
//  ---------+---------------------------------------+--------------------------
//  input    | in_valid, in_stall, level             | valid && !stall
//  output   | out_valid, out_stall, packed_color    | valid && !stall
//  config   | cfg_valid, cfg_ready, cfg_index, data | valid && ready
//
//  One level per clock while in_stall is low; a result passes through the
//  table read register, then the output queue.
//  After reset and after every config write, a build sequencer fills the
//  256-entry table, writing zero for levels at or below the cutoff without
//  the division steps; inputs stall during the build.
//  Input stalls while three results are queued or in flight.
// ----------------------------------------------------------------------------
`include "intensity_to_rgba_colormap_top_defines.svh"

module intensity_to_rgba_colormap_top #(
	parameter int MAX_LEVEL = 255
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [icm_pkg::LEVEL_W-1:0]   level,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [icm_pkg::COLOR_W-1:0]   packed_color,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [icm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [icm_pkg::CFG_W-1:0]     cfg_data
);

	icm_pkg::cfg_t    cfg;
	icm_pkg::lut_wr_t wr;
	logic restart, busy, accept, pop, s1_valid;
	logic [icm_pkg::COLOR_W-1:0] rd_data;
	logic [1:0] fifo_cnt;

	assign cfg_ready = 1'b1;

	icm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg),
		.restart  (restart)
	);

	icm_builder #(.MAX_LEVEL(MAX_LEVEL)) u_builder (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.restart (restart),
		.busy    (busy),
		.wr      (wr)
	);

	// Hold input while building or when no queue slot remains for the beat.
	assign in_stall = busy || ((3'(fifo_cnt) + 3'(s1_valid)) > 3'd2);
	assign accept   = in_valid && !in_stall;

	icm_lut u_lut (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (accept),
		.rd_addr (level),
		.rd_data (rd_data)
	);

	// Track the read in flight; its data lands in the queue next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= accept;
		end
	end

	assign pop = out_valid && !out_stall;

	icm_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s1_valid),
		.push_data (rd_data),
		.pop       (pop),
		.not_empty (out_valid),
		.head_data (packed_color),
		.count     (fifo_cnt)
	);

	`ICM_ASSERT_IMPL(a_no_accept_busy, clk, arst_n, accept, !busy)
	`ICM_ASSERT_NEXT(a_read_in_flight, clk, arst_n, accept, s1_valid)

endmodule

// ===== tb/icm_colormap_checker.sv =====
// ----------------------------------------------------------------------------
// icm_colormap_checker
// Watches the config, level and color channels of the colormap, predicts the
// packed color of every level beat and compares it with the color beats.
// ----------------------------------------------------------------------------
module icm_colormap_checker #(
	parameter int MAX_LEVEL = 255
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [icm_pkg::LEVEL_W-1:0]   level,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [icm_pkg::COLOR_W-1:0]   packed_color,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [icm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [icm_pkg::CFG_W-1:0]     cfg_data,
	output int                            fail_count,
	output int                            colors_pending,
	output int                            colors_seen
);
	import icm_pkg::*;

	localparam longint unsigned S16 = 64'd65535;
	localparam longint unsigned S32 = S16 * S16;
	localparam longint unsigned S48 = S32 * S16;

	cfg_t regs;
	logic [COLOR_W-1:0] color_q[$];

	assign colors_pending = color_q.size();

	function automatic logic [7:0] chan_byte(longint unsigned lum, longint unsigned x);
		return 8'((64'd255 * lum * x + S48 / 2) / S48);
	endfunction

	function automatic logic [COLOR_W-1:0] color_of(logic [LEVEL_W-1:0] lv_in);
		longint unsigned lv, m, d, n, lum, h6, sector, fr, sat;
		logic [7:0] cv, cp, cq, ct, r, g, b;
		m  = MAX_LEVEL;
		lv = lv_in;
		if (lv > m)
			lv = m;
		if (lv * S16 <= longint'(regs.low_threshold) * m)
			return '0;
		d   = m * (S16 - regs.low_threshold);
		n   = (S16 - regs.base_luma) * (m - lv);
		lum = ((d - n) * S16 + d / 2) / d;
		h6     = 6 * longint'(regs.hue);
		sector = h6 / S16;
		fr     = h6 % S16;
		if (sector >= 6)
			sector = 0;
		sat = regs.saturation;
		cv = chan_byte(lum, S32);
		cp = chan_byte(lum, S16 * (S16 - sat));
		cq = chan_byte(lum, S32 - fr * sat);
		ct = chan_byte(lum, S32 - (S16 - fr) * sat);
		case (sector)
			0: begin r = cv; g = ct; b = cp; end
			1: begin r = cq; g = cv; b = cp; end
			2: begin r = cp; g = cv; b = ct; end
			3: begin r = cp; g = cq; b = cv; end
			4: begin r = ct; g = cp; b = cv; end
			default: begin r = cv; g = cp; b = cq; end
		endcase
		return {8'd255, b, g, r};
	endfunction

	task automatic report(string what, logic [COLOR_W-1:0] got, logic [COLOR_W-1:0] want);
		fail_count++;
		$display("MISMATCH %s: got %08h want %08h", what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [COLOR_W-1:0] want;
		if (!arst_n) begin
			regs <= '0;
			color_q.delete();
			fail_count  = 0;
			colors_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LOW_THRESHOLD: regs.low_threshold <= cfg_data;
					REG_BASE_LUMA:     regs.base_luma     <= cfg_data;
					REG_HUE:           regs.hue           <= cfg_data;
					REG_SATURATION:    regs.saturation    <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				color_q.push_back(color_of(level));
			if (out_valid && !out_stall) begin
				colors_seen++;
				if (color_q.size() == 0)
					report("unexpected color", packed_color, '0);
				else begin
					want = color_q.pop_front();
					if (packed_color[31:24] !== want[31:24])
						report("alpha", packed_color, want);
					if (packed_color[23:16] !== want[23:16])
						report("blue", packed_color, want);
					if (packed_color[15:8] !== want[15:8])
						report("green", packed_color, want);
					if (packed_color[7:0] !== want[7:0])
						report("red", packed_color, want);
				end
			end
		end
	end
endmodule

// ===== tb/tb_intensity_to_rgba_colormap_top.sv =====
// ----------------------------------------------------------------------------
// tb_intensity_to_rgba_colormap_top
// Drives levels and register settings into the colormap over several phases
// (reset values, each hue sector, full-scale extremes, random settings) with
// random gaps and output stalls; the checker predicts and compares colors.
// ----------------------------------------------------------------------------
module tb_intensity_to_rgba_colormap_top;
	import icm_pkg::*;

	localparam int  N_PHASES        = 10;
	localparam int  ITEMS_PER_PHASE = 73;
	localparam int  IDLE_LIMIT      = 40000;
	localparam logic [CFG_IDX_W-1:0] REG_BEYOND_LAST = REG_SATURATION + 8'd1;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [LEVEL_W-1:0]   level;
	logic                 out_valid;
	logic                 out_stall;
	logic [COLOR_W-1:0]   packed_color;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	int  fail_count, colors_pending, colors_seen;
	int  idle_cycles;
	int  stall_left;
	int  levels_sent;
	bit  in_quiet, out_quiet;

	intensity_to_rgba_colormap_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .level(level),
		.out_valid(out_valid), .out_stall(out_stall), .packed_color(packed_color),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	icm_colormap_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .level(level),
		.out_valid(out_valid), .out_stall(out_stall), .packed_color(packed_color),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .colors_pending(colors_pending),
		.colors_seen(colors_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Color side: after each beat, draw how long to hold stall high.
	always @(posedge clk or negedge arst_n) begin
		int n;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (out_valid && !out_stall) begin
			n = out_quiet ? 0 : $urandom_range(0, 17);
			stall_left <= n;
			out_stall  <= (n != 0);
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= (stall_left > 1);
		end
	end

	// Watchdog: end the run when no beat on any channel for too long.
	// A table rebuild after a register write stalls input and shows no beat.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
			|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no beat in %0d cycles", IDLE_LIMIT);
			$display("intensity_to_rgba_colormap_top verification failed");
			$finish;
		end
	end

	// Send one level beat after a random gap; keep valid high when the gap is zero.
	task automatic send_level(logic [LEVEL_W-1:0] v);
		int gap;
		gap = in_quiet ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		level    <= v;
		do @(posedge clk); while (in_stall);
		levels_sent++;
	endtask

	// Write one register; the caller drops cfg_valid after the last write.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Drain every pending color, then let the pipeline settle.
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (colors_pending != 0) @(negedge clk);
		repeat (6) @(posedge clk);
	endtask

	initial begin
		cfg_t s;
		logic [LEVEL_W-1:0] lv;
		in_valid    <= 1'b0;
		level       <= '0;
		cfg_valid   <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		in_quiet    = 1'b0;
		out_quiet   = 1'b0;
		levels_sent = 0;
		arst_n      <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: level extremes and walking ones under reset settings.
		for (int i = 0; i < LEVEL_W; i++) send_level(LEVEL_W'(1) << i);
		send_level('0);
		send_level('1);
		send_level(8'd1);
		send_level(8'd254);
		send_level(8'h55);
		send_level(8'hAA);
		send_level(8'd128);
		send_level(8'd127);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain();
			s = {$urandom, $urandom};
			// Phases 0..5 land in each hue sector; then the extremes.
			if (ph < 6)
				s.hue = 16'(ph * 10923 + $urandom_range(0, 10000));
			else if (ph == 6)
				s = '1;                          // full threshold: all black
			else if (ph == 7)
				s = {16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF};  // hue wraps to sector 0
			else if (ph == 8)
				s = '0;
			else
				s.low_threshold = 16'($urandom_range(0, 40000));
			write_reg(REG_LOW_THRESHOLD, s.low_threshold);
			write_reg(REG_BASE_LUMA, s.base_luma);
			write_reg(REG_HUE, s.hue);
			write_reg(REG_SATURATION, s.saturation);
			// Out-of-range index must leave the settings alone.
			write_reg(CFG_IDX_W'($urandom_range(REG_BEYOND_LAST, 255)), 16'($urandom));
			cfg_valid <= 1'b0;
			in_quiet  = ($urandom_range(0, 3) == 0);
			out_quiet = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				case ($urandom_range(0, 7))
					0: lv = '0;
					1: lv = '1;
					default: lv = 8'($urandom);
				endcase
				send_level(lv);
			end
		end

		drain();
		$display("covered %0d levels over %0d register settings (hue sectors, extremes, random)",
			levels_sent, N_PHASES + 1);
		$display("checked %0d colors, %0d mismatches", colors_seen, fail_count);
		if (fail_count == 0)
			$display("intensity_to_rgba_colormap_top verification clean");
		else
			$display("intensity_to_rgba_colormap_top verification failed");
		$finish;
	end
endmodule
